### hdl/wcr_pkg.sv
`default_nettype none

package wcr_pkg;

	// Field widths of a hit and of a result
	localparam int COORD_W      = 16;
	localparam int WEIGHT_W     = 16;
	localparam int HITS_W       = 9;
	localparam int MAX_HITS_DEF = 256;

	// Square root operates on the quotient of deviation sum by weight sum
	localparam int SQ_IN_W = 32;
	localparam int ROOT_W  = 16;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // hit transfer this cycle
		logic div_mean;    // start moment / weight division
		logic mean_take;   // capture signed mean from quotient
		logic dev_start;   // start deviation sweep over the store
		logic div_rms;     // start deviation / weight division
		logic sqrt_start;  // start square root of quotient
		logic out_load;    // load result register and clear sums
	} wcr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic wsum_zero;
		logic div_done;
		logic dev_done;
		logic sqrt_done;
		logic out_busy;    // result register full and not taken
	} wcr_stat_t;

endpackage

`default_nettype wire

### hdl/wcr_hit_if.sv
`default_nettype none

interface wcr_hit_if import wcr_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  coordinate;
	logic        [WEIGHT_W-1:0] hit_weight;
	logic                       last_hit;

	modport source (output valid, coordinate, hit_weight, last_hit, input ready);
	modport sink   (input valid, coordinate, hit_weight, last_hit, output ready);
endinterface

`default_nettype wire

### hdl/wcr_res_if.sv
`default_nettype none

interface wcr_res_if import wcr_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  weighted_mean;
	logic        [ROOT_W-1:0]   weighted_rms;
	logic        [HITS_W-1:0]   hits_used;
	logic                       zero_weight;
	logic                       overflowed;

	modport source (output valid, weighted_mean, weighted_rms, hits_used, zero_weight,
		overflowed, input ready);
	modport sink   (input valid, weighted_mean, weighted_rms, hits_used, zero_weight,
		overflowed, output ready);
endinterface

`default_nettype wire

### hdl/wcr_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module wcr_div import wcr_pkg::*; #(
	parameter int DW = 57,
	parameter int VW = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic      [DW-1:0] quot,
	output logic               done
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quot_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic [VW+1:0] trial;

	// shift in next dividend bit and try a subtraction
	assign rem_sh = {rem_q[VW-1:0], quot_q[DW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!trial[VW+1]) begin
				rem_q  <= trial[VW:0];
				quot_q <= {quot_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

`default_nettype wire

### hdl/wcr_sqrt.sv
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle
module wcr_sqrt import wcr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SQ_IN_W-1:0] value,
	output logic      [ROOT_W-1:0]  root,
	output logic                    done
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CW    = $clog2(ROOT_W + 1);

	logic [SQ_IN_W-1:0] val_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+2:0]   trial;

	assign rem_sh = {rem_q, val_q[SQ_IN_W-1 -: 2]};
	assign trial  = {1'b0, rem_sh} - {3'b000, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[SQ_IN_W-3:0], 2'b00};
			if (!trial[REM_W+2]) begin
				rem_q  <= trial[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

`default_nettype wire

### hdl/wcr_dpath.sv
`default_nettype none

module wcr_dpath import wcr_pkg::*; #(
	parameter int MAX_HITS = MAX_HITS_DEF,
	parameter int AW       = 8,
	parameter int CNT_W    = 9,
	parameter int WSUM_W   = 25,
	parameter int MSUM_W   = 41,
	parameter int DEV_W    = 57
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wcr_cmd_t                   cmd,
	output wcr_stat_t                       stat,
	input  wire logic signed [COORD_W-1:0]  coordinate,
	input  wire logic        [WEIGHT_W-1:0] hit_weight,
	output logic signed      [COORD_W-1:0]  weighted_mean,
	output logic             [ROOT_W-1:0]   weighted_rms,
	output logic             [HITS_W-1:0]   hits_used,
	output logic                            zero_weight,
	output logic                            overflowed,
	output logic                            out_valid,
	input  wire logic                       out_ready
);

	localparam int ENT_W = COORD_W + WEIGHT_W;

	logic [ENT_W-1:0]          mem [MAX_HITS];
	logic [CNT_W-1:0]          cnt_q;
	logic [WSUM_W-1:0]         wsum_q;
	logic signed [MSUM_W-1:0]  msum_q;
	logic                      drop_q;
	logic                      full;
	logic                      store;
	logic signed [ENT_W:0]     prod;

	// hit store and running sums
	assign full  = cnt_q == CNT_W'(MAX_HITS);
	assign store = cmd.load && !full;
	assign prod  = coordinate * $signed({1'b0, hit_weight});

	always_ff @(posedge clk) begin
		if (store) begin
			mem[cnt_q[AW-1:0]] <= {coordinate, hit_weight};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wsum_q <= '0;
			msum_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.out_load) begin
			cnt_q  <= '0;
			wsum_q <= '0;
			msum_q <= '0;
			drop_q <= 1'b0;
		end else if (store) begin
			cnt_q  <= cnt_q + 1'b1;
			wsum_q <= wsum_q + WSUM_W'(hit_weight);
			msum_q <= msum_q + MSUM_W'(prod);
		end else if (cmd.load) begin
			drop_q <= 1'b1;
		end
	end

	// shared divider: moment magnitude first, deviation sum second
	logic              msum_neg;
	logic [MSUM_W-1:0] msum_mag;
	logic [DEV_W-1:0]  dev_q;
	logic [DEV_W-1:0]  dividend;
	logic [DEV_W-1:0]  quot;
	logic              div_done;

	assign msum_neg = msum_q[MSUM_W-1];
	assign msum_mag = msum_neg ? MSUM_W'(-msum_q) : MSUM_W'(msum_q);
	assign dividend = cmd.div_rms ? dev_q : DEV_W'(msum_mag);

	wcr_div #(.DW(DEV_W), .VW(WSUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_mean || cmd.div_rms),
		.dividend (dividend),
		.divisor  (wsum_q),
		.quot     (quot),
		.done     (div_done)
	);

	// mean truncates toward zero: sign applied to magnitude quotient
	logic signed [COORD_W-1:0] mean_q;
	logic        [COORD_W-1:0] qlow;

	assign qlow = quot[COORD_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mean_take) begin
			mean_q <= msum_neg ? COORD_W'(-qlow) : qlow;
		end
	end

	// deviation sweep: read, square, weight, accumulate
	logic [CNT_W-1:0]             addr_q;
	logic                         dev_busy_q;
	logic                         issue;
	logic                         dev_done;
	logic [ENT_W-1:0]             rd_s1;
	logic                         v_s1, v_s2, v_s3;
	logic signed [COORD_W:0]      diff;
	logic [COORD_W-1:0]           adiff;
	logic [2*COORD_W-1:0]         sq_s2;
	logic [WEIGHT_W-1:0]          w_s2;
	logic [2*COORD_W+WEIGHT_W-1:0] prod_s3;

	assign issue    = dev_busy_q && (addr_q < cnt_q);
	assign dev_done = dev_busy_q && !issue && !v_s1 && !v_s2 && !v_s3;
	assign diff     = $signed({rd_s1[ENT_W-1], rd_s1[ENT_W-1 -: COORD_W]})
		- $signed({mean_q[COORD_W-1], mean_q});
	assign adiff    = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_busy_q <= 1'b0;
			addr_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.dev_start) begin
				dev_busy_q <= 1'b1;
				addr_q     <= '0;
			end else begin
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (dev_done) begin
					dev_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[addr_q[AW-1:0]];
		end
		sq_s2   <= adiff * adiff;
		w_s2    <= rd_s1[WEIGHT_W-1:0];
		prod_s3 <= sq_s2 * w_s2;
		if (cmd.dev_start) begin
			dev_q <= '0;
		end else if (v_s3) begin
			dev_q <= dev_q + DEV_W'(prod_s3);
		end
	end

	// square root of the deviation quotient
	logic [ROOT_W-1:0] root;
	logic              sqrt_done;

	wcr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.value  (quot[SQ_IN_W-1:0]),
		.root   (root),
		.done   (sqrt_done)
	);

	// result register
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] mean_o_q;
	logic [ROOT_W-1:0]         rms_o_q;
	logic [HITS_W-1:0]         hits_o_q;
	logic                      zero_o_q;
	logic                      drop_o_q;
	logic                      wsum_zero;

	assign wsum_zero = wsum_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_o_q <= wsum_zero ? '0 : mean_q;
			rms_o_q  <= wsum_zero ? '0 : root;
			hits_o_q <= HITS_W'(cnt_q);
			zero_o_q <= wsum_zero;
			drop_o_q <= drop_q;
		end
	end

	assign weighted_mean = mean_o_q;
	assign weighted_rms  = rms_o_q;
	assign hits_used     = hits_o_q;
	assign zero_weight   = zero_o_q;
	assign overflowed    = drop_o_q;
	assign out_valid     = out_valid_q;

	assign stat.wsum_zero = wsum_zero;
	assign stat.div_done  = div_done;
	assign stat.dev_done  = dev_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.out_busy  = out_valid_q && !out_ready;

endmodule

`default_nettype wire

### hdl/wcr_ctrl.sv
`default_nettype none

module wcr_ctrl import wcr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_last,
	output logic           in_ready,
	output wcr_cmd_t       cmd,
	input  wire wcr_stat_t stat
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_MEAN,
		S_DEV,
		S_RMS,
		S_SQRT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   div_mean_q, mean_take_q, dev_start_q, div_rms_q, sqrt_start_q;
	logic   xfer;
	logic   out_load;

	assign xfer     = in_valid && ready_q;
	assign out_load = (state_q == S_DONE) && !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			ready_q      <= 1'b1;
			div_mean_q   <= 1'b0;
			mean_take_q  <= 1'b0;
			dev_start_q  <= 1'b0;
			div_rms_q    <= 1'b0;
			sqrt_start_q <= 1'b0;
		end else begin
			div_mean_q   <= 1'b0;
			mean_take_q  <= 1'b0;
			dev_start_q  <= 1'b0;
			div_rms_q    <= 1'b0;
			sqrt_start_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (xfer && in_last) begin
						ready_q <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.wsum_zero) begin
						state_q <= S_DONE;
					end else begin
						div_mean_q <= 1'b1;
						state_q    <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (stat.div_done) begin
						mean_take_q <= 1'b1;
						dev_start_q <= 1'b1;
						state_q     <= S_DEV;
					end
				end
				S_DEV: begin
					if (stat.dev_done) begin
						div_rms_q <= 1'b1;
						state_q   <= S_RMS;
					end
				end
				S_RMS: begin
					if (stat.div_done) begin
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (stat.sqrt_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						ready_q <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				default: begin
					ready_q <= 1'b1;
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign in_ready       = ready_q;
	assign cmd.load       = xfer;
	assign cmd.div_mean   = div_mean_q;
	assign cmd.mean_take  = mean_take_q;
	assign cmd.dev_start  = dev_start_q;
	assign cmd.div_rms    = div_rms_q;
	assign cmd.sqrt_start = sqrt_start_q;
	assign cmd.out_load   = out_load;

endmodule

`default_nettype wire

### hdl/weighted_centroid_rms.sv
// Channel  Dir  Payload                                                    Handshake
// hits     in   coordinate, hit_weight, last_hit                           valid/ready
// result   out  weighted_mean, weighted_rms, hits_used, zero_weight,       valid/ready
//               overflowed
//
// Hits transfer at one per cycle while a set is loading (store write port).
// After the last hit the result is formed by the bit-serial divider (used twice), the
// store read sweep and the square root; a zero weight sum skips straight to the result.
// Reset clears counters, sums and control; the store needs no clearing.
// The result register lets a new set load while a result waits; a set whose
// result is ready holds in the done state until the register frees.
`default_nettype none

module weighted_centroid_rms import wcr_pkg::*; #(
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wcr_hit_if.sink   hits,
	wcr_res_if.source result
);

	localparam int AW     = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CNT_W  = $clog2(MAX_HITS + 1);
	localparam int WSUM_W = WEIGHT_W + CNT_W;
	localparam int MSUM_W = COORD_W + WEIGHT_W + 1 + CNT_W;
	localparam int DEV_W  = 2 * COORD_W + WEIGHT_W + CNT_W;

	wcr_cmd_t  cmd;
	wcr_stat_t stat;

	wcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hits.valid),
		.in_last  (hits.last_hit),
		.in_ready (hits.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	wcr_dpath #(
		.MAX_HITS (MAX_HITS),
		.AW       (AW),
		.CNT_W    (CNT_W),
		.WSUM_W   (WSUM_W),
		.MSUM_W   (MSUM_W),
		.DEV_W    (DEV_W)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.coordinate    (hits.coordinate),
		.hit_weight    (hits.hit_weight),
		.weighted_mean (result.weighted_mean),
		.weighted_rms  (result.weighted_rms),
		.hits_used     (result.hits_used),
		.zero_weight   (result.zero_weight),
		.overflowed    (result.overflowed),
		.out_valid     (result.valid),
		.out_ready     (result.ready)
	);

	// a closing hit stops further transfers until its result is loaded
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		hits.valid && hits.ready && hits.last_hit |=> !hits.ready)
		else $error("hit accepted after the closing hit");

	// zero weight sum forces zero outputs
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.zero_weight |->
			result.weighted_mean == '0 && result.weighted_rms == '0)
		else $error("zero weight result not forced to zero");

	// dropped hits only when the store was full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.overflowed |-> result.hits_used == HITS_W'(MAX_HITS))
		else $error("overflow flagged with store not full");

endmodule

`default_nettype wire
